@@ hdl/cfr_pkg.sv @@
// shared types and constants of the command frame responder
package cfr_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int DIGITS      = 7;
   localparam int CNT_W       = $clog2(FRAME_BYTES);
   localparam int DIGITS_W    = 4 * DIGITS;

   // result beats per answered frame
   localparam int REPLY_ITEMS = FRAME_BYTES;
   localparam int FWD_ITEMS   = 2 * FRAME_BYTES;
   localparam int IDX_W       = $clog2(FWD_ITEMS);

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] CHAR_R    = 8'h72;
   localparam logic [7:0] CHAR_X    = 8'h58;
   localparam logic [7:0] CHAR_Y    = 8'h59;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_SIX  = 8'h36;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // destination codes
   localparam logic [1:0] DEST_HOST = 2'd0;
   localparam logic [1:0] DEST_X    = 2'd1;
   localparam logic [1:0] DEST_Y    = 2'd2;

   // job kinds
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_X     = 2'd1;
   localparam logic [1:0] KIND_Y     = 2'd2;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // one classified frame waiting to be answered
   typedef struct packed {
      logic [1:0]          kind;
      frame_type           frame;
      logic [DIGITS_W-1:0] x_digits;
      logic [DIGITS_W-1:0] y_digits;
      logic                session_open;
   } job_type;

endpackage

@@ hdl/cfr_front.sv @@
// front part: gathers bytes into frames, classifies them and updates session and digits
module cfr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [7:0]      req_rx_byte,
   output logic            req_stall,
   input  logic            q_full,
   output logic            push,
   output cfr_pkg::job_type push_job
);
   import cfr_pkg::*;

   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   frame_type           frame_ff;
   logic                session_ff, session_in;
   logic [DIGITS_W-1:0] x_digits_ff, x_digits_in;
   logic [DIGITS_W-1:0] y_digits_ff, y_digits_in;

   logic                accept;
   logic                frame_done;
   frame_type           full_frame;
   logic                a_frame;
   logic                cmd_one, cmd_two;
   logic                is_x, is_y;
   logic [DIGITS_W-1:0] new_digits;
   logic [DIGITS_W-1:0] old_digits;
   logic                emit;
   logic [1:0]          kind;

   // hold the last byte of a frame while the queue is full
   assign req_stall  = q_full && (byte_count_ff == CNT_W'(FRAME_BYTES - 1));
   assign accept     = req_valid && !req_stall;
   assign frame_done = accept && (byte_count_ff == CNT_W'(FRAME_BYTES - 1));

   // complete frame with the incoming beat as its last byte
   always_comb begin
      full_frame = frame_ff;
      full_frame[FRAME_BYTES-1] = req_rx_byte;
   end

   // match of the A00nrr00 template
   always_comb begin
      a_frame = (full_frame[0] == CHAR_A) && (full_frame[1] == CHAR_ZERO) &&
                (full_frame[2] == CHAR_ZERO) && (full_frame[4] == CHAR_R) &&
                (full_frame[5] == CHAR_R) && (full_frame[6] == CHAR_ZERO) &&
                (full_frame[7] == CHAR_ZERO) &&
                (full_frame[3] inside {[CHAR_ONE:CHAR_SIX]});
      cmd_one = a_frame && (full_frame[3] == CHAR_ONE);
      cmd_two = a_frame && (full_frame[3] == CHAR_TWO);
      is_x    = full_frame[0] == CHAR_X;
      is_y    = full_frame[0] == CHAR_Y;
   end

   // digit update: decimal bytes overwrite, others keep the old digit
   always_comb begin
      old_digits = is_x ? x_digits_ff : y_digits_ff;
      new_digits = old_digits;
      for (int k = 0; k < DIGITS; k++) begin
         if (full_frame[k+1] inside {[CHAR_ZERO:CHAR_NINE]}) begin
            new_digits[DIGITS_W-1-4*k -: 4] = full_frame[k+1][3:0];
         end
      end
   end

   // session rules and job kind
   always_comb begin
      session_in  = session_ff;
      x_digits_in = x_digits_ff;
      y_digits_in = y_digits_ff;
      emit        = 1'b0;
      kind        = KIND_REPLY;
      if (frame_done) begin
         if (!session_ff) begin
            if (cmd_one) begin
               session_in = 1'b1;
               emit       = 1'b1;
            end
         end else if (a_frame) begin
            emit = 1'b1;
            if (cmd_two) begin
               session_in = 1'b0;
            end
         end else if (is_x) begin
            emit        = 1'b1;
            kind        = KIND_X;
            x_digits_in = new_digits;
         end else if (is_y) begin
            emit        = 1'b1;
            kind        = KIND_Y;
            y_digits_in = new_digits;
         end
      end
   end

   assign byte_count_in = accept ? byte_count_ff + CNT_W'(1) : byte_count_ff;

   // job toward the back part
   assign push                  = emit;
   assign push_job.kind         = kind;
   assign push_job.frame        = full_frame;
   assign push_job.x_digits     = x_digits_in;
   assign push_job.y_digits     = y_digits_in;
   assign push_job.session_open = session_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         session_ff    <= 1'b0;
         x_digits_ff   <= '0;
         y_digits_ff   <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         session_ff    <= session_in;
         x_digits_ff   <= x_digits_in;
         y_digits_ff   <= y_digits_in;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff[byte_count_ff] <= req_rx_byte;
      end
   end

endmodule

@@ hdl/cfr_queue.sv @@
// short job queue between the front and back parts
module cfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output cfr_pkg::job_type head_job
);
   import cfr_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   // the front never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into full queue");

   // fill count stays within depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

@@ hdl/cfr_back.sv @@
// back part: walks the head job and sends its result beats through an output register
module cfr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  cfr_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_dest,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic [27:0]      rsp_x_digits,
   output logic [27:0]      rsp_y_digits,
   output logic             rsp_session_open
);
   import cfr_pkg::*;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [1:0]          dest_ff;
   logic [7:0]          byte_ff;
   logic                last_ff;
   logic [DIGITS_W-1:0] x_ff, y_ff;
   logic                sess_ff;

   logic                load;
   logic [1:0]          item_dest;
   logic [7:0]          item_byte;
   logic                item_last;
   logic [7:0]          frame_byte;

   // refill the output register when it is empty or being taken
   assign load       = head_valid && (!valid_ff || !rsp_stall);
   assign frame_byte = head_job.frame[idx_ff[CNT_W-1:0]];

   // result beat at the current index of the head job
   always_comb begin
      item_dest = DEST_HOST;
      item_byte = frame_byte;
      item_last = 1'b0;
      case (head_job.kind)
         KIND_REPLY: begin
            item_last = idx_ff == IDX_W'(REPLY_ITEMS - 1);
            if (idx_ff == '0) begin
               item_byte = CHAR_B;
            end else if (idx_ff > IDX_W'(5)) begin
               item_byte = CHAR_ONE;
            end
         end
         KIND_X, KIND_Y: begin
            item_last = idx_ff == IDX_W'(FWD_ITEMS - 1);
            if (idx_ff < IDX_W'(FRAME_BYTES)) begin
               item_dest = (head_job.kind == KIND_X) ? DEST_X : DEST_Y;
            end else if (idx_ff == IDX_W'(FRAME_BYTES)) begin
               item_byte = CHAR_B;
            end
         end
         default: begin
            item_last = 1'b1;
         end
      endcase
   end

   assign pop = load && item_last;

   // index and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = item_last ? '0 : idx_ff + IDX_W'(1);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         dest_ff <= item_dest;
         byte_ff <= item_byte;
         last_ff <= item_last;
         x_ff    <= head_job.x_digits;
         y_ff    <= head_job.y_digits;
         sess_ff <= head_job.session_open;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_dest         = dest_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last         = last_ff;
   assign rsp_x_digits     = x_ff;
   assign rsp_y_digits     = y_ff;
   assign rsp_session_open = sess_ff;

`ifndef ASSERT_OFF
   // the final beat of a frame is always a host reply byte
   a_last_to_host: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> dest_ff == DEST_HOST)
      else $error("last beat not addressed to host");

   // a job is popped only on its final beat
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff && last_ff && idx_ff == '0)
      else $error("job popped before its last beat");
`endif

endmodule

@@ hdl/command_frame_responder.sv @@
// top level of the command frame responder
//
// Input channel req_: one host byte per beat on req_rx_byte. Bytes are
// gathered into 8-byte frames; only the eighth byte of a frame can cause
// results. Result channel rsp_: one transmitted byte per beat with its link
// (rsp_dest), rsp_last on the final beat of a frame, and the X/Y digits and
// session flag as they stand after that frame.
// The job of a frame is queued at the edge that accepts its eighth byte,
// and its beats leave through the output register. An answered frame
// gives 8 beats (A command reply) or 16 beats (X/Y forward and echo), one
// beat per cycle while rsp_stall is low. Input bytes are taken one per
// cycle while req_stall is low; the pace is set by the result channel
// draining a frame's beats, so X/Y frames are paced by their result beats.
// A two-entry job queue parts the front from the back; when it is full the
// eighth byte of the next frame is stalled, while the first seven still flow.
// A stall on rsp_ holds the output beat unchanged and backs up into the queue.
// Reset clears the byte count, closes the session and zeroes all digits.
module command_frame_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_dest,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [27:0] rsp_x_digits,
   output logic [27:0] rsp_y_digits,
   output logic        rsp_session_open
);
   import cfr_pkg::*;

   logic    q_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // byte gathering and classification
   cfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   // classified jobs
   cfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // result beat generation
   cfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest         (rsp_dest),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .rsp_x_digits     (rsp_x_digits),
      .rsp_y_digits     (rsp_y_digits),
      .rsp_session_open (rsp_session_open)
   );

endmodule
